/* sv/eacl_pkg.sv */
// Shared types, codes and constants for the echo acknowledge command link.
`default_nettype none

package eacl_pkg;

	localparam int unsigned PayloadDepthDef = 16;
	localparam logic [7:0] EchoKey = 8'd85;
	localparam logic [7:0] CmdHigh = 8'd128;
	localparam logic [7:0] CmdMask = 8'd127;
	localparam logic [15:0] TimeoutReset = 16'd50;

	localparam logic [2:0] KindRxByte   = 3'd0;
	localparam logic [2:0] KindTick     = 3'd1;
	localparam logic [2:0] KindLoad     = 3'd2;
	localparam logic [2:0] KindSendData = 3'd3;
	localparam logic [2:0] KindSendCmd  = 3'd4;
	localparam logic [2:0] KindReply    = 3'd5;

	localparam logic [2:0] EvNone      = 3'd0;
	localparam logic [2:0] EvDataByte  = 3'd1;
	localparam logic [2:0] EvEmptyMsg  = 3'd2;
	localparam logic [2:0] EvDataReq   = 3'd3;
	localparam logic [2:0] EvSendDone  = 3'd4;
	localparam logic [2:0] EvTimeout   = 3'd5;
	localparam logic [2:0] EvEchoError = 3'd6;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RX_LEN,
		PH_RX_DATA,
		PH_AWAIT_REPLY,
		PH_CMD_ECHO_SEND,
		PH_CMD_ECHO_RECV,
		PH_BODY_ECHO
	} eacl_phase_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
		logic [3:0] index;
		logic [4:0] length;
	} eacl_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [2:0] event_res;
		logic [7:0] cmd;
		logic [7:0] data_out;
		logic [7:0] position;
		logic       last;
	} eacl_res_t;

endpackage

`default_nettype wire

/* sv/echo_ack_command_link.sv */
// Top level of the echo acknowledge command link.
`default_nettype none

// Every item (received byte, tick, payload load, send or reply) yields exactly one result.
// An item is registered on acceptance, decoded against the link state while it is held in that
// register, and its result is held in an output register, which keeps it while the result side
// stalls; one item is taken every cycle while the result side does not stall, and throughput
// is set only by the result side's stall. The timeout register is written
// through the cfg channel, which is always ready, and should be written only while the
// link is idle.
module echo_ack_command_link #(
	parameter int unsigned PAYLOAD_DEPTH = eacl_pkg::PayloadDepthDef
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  eacl_pkg::eacl_item_t item,
	output logic                 res_valid,
	input  wire                  res_stall,
	output eacl_pkg::eacl_res_t  res,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [15:0]           cfg_data
);
	import eacl_pkg::*;

	eacl_item_t  item_s1;
	logic        valid_s1;
	eacl_res_t   res_d;
	eacl_res_t   res_q;
	logic        res_valid_q;
	logic [15:0] timeout_q;
	logic        advance;
	logic        accept;

	assign advance    = valid_s1 && !(res_valid_q && res_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	eacl_fsm #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.item         (item_s1),
		.timeout_ticks(timeout_q),
		.res          (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			timeout_q   <= TimeoutReset;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

/* sv/eacl_fsm.sv */
// Link state machine, payload buffer and per-item result logic.
`default_nettype none

module eacl_fsm #(
	parameter int unsigned PAYLOAD_DEPTH = eacl_pkg::PayloadDepthDef
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  eacl_pkg::eacl_item_t item,
	input  wire [15:0]           timeout_ticks,
	output eacl_pkg::eacl_res_t  res
);
	import eacl_pkg::*;

	localparam int unsigned StoreDepth = (PAYLOAD_DEPTH < 16) ? PAYLOAD_DEPTH : 16;
	localparam int unsigned AW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
	localparam logic [7:0] DepthB = 8'(PAYLOAD_DEPTH);
	localparam logic [7:0] StoreB = 8'(StoreDepth);

	eacl_phase_t phase_q, phase_d;
	logic [7:0]  cur_cmd_q, cur_cmd_d;
	logic [7:0]  msg_len_q, msg_len_d;
	logic [7:0]  byte_cnt_q, byte_cnt_d;
	logic [7:0]  exp_echo_q, exp_echo_d;
	logic [15:0] wait_q, wait_d;
	logic [7:0]  store_q [StoreDepth];

	logic        is_rx, is_tick, is_load, is_send_data, is_send_cmd, is_reply;
	logic        echo_ok, more, fin, tmo;
	logic [15:0] limit, wait_inc;
	logic [7:0]  clamp_len, rd_byte, cmd_hi;

	assign is_rx        = item.kind == KindRxByte;
	assign is_tick      = item.kind == KindTick;
	assign is_load      = item.kind == KindLoad;
	assign is_send_data = item.kind == KindSendData;
	assign is_send_cmd  = item.kind == KindSendCmd;
	assign is_reply     = item.kind == KindReply;

	assign echo_ok   = item.value == exp_echo_q;
	assign more      = (byte_cnt_q < msg_len_q) && (byte_cnt_q < DepthB);
	assign fin       = 8'(byte_cnt_q + 8'd1) == msg_len_q;
	assign limit     = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
	assign wait_inc  = (wait_q == 16'hFFFF) ? wait_q : 16'(wait_q + 16'd1);
	assign tmo       = wait_inc >= limit;
	assign clamp_len = ({3'd0, item.length} > DepthB) ? DepthB : {3'd0, item.length};
	assign rd_byte   = (byte_cnt_q < StoreB) ? store_q[byte_cnt_q[AW-1:0]] : 8'd0;
	assign cmd_hi    = 8'(item.value + CmdHigh);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (is_rx) begin
					phase_d = (item.value >= CmdHigh) ? PH_RX_LEN : PH_AWAIT_REPLY;
				end else if (is_send_data) begin
					phase_d = PH_CMD_ECHO_SEND;
				end else if (is_send_cmd) begin
					phase_d = PH_CMD_ECHO_RECV;
				end
			end
			PH_RX_LEN: begin
				if (is_rx) begin
					phase_d = (item.value == 8'd0) ? PH_IDLE : PH_RX_DATA;
				end else if (is_tick && tmo) begin
					phase_d = PH_IDLE;
				end
			end
			PH_RX_DATA: begin
				if (is_rx && fin) begin
					phase_d = PH_IDLE;
				end else if (is_tick && tmo) begin
					phase_d = PH_IDLE;
				end
			end
			PH_AWAIT_REPLY: begin
				if (is_reply) begin
					phase_d = PH_BODY_ECHO;
				end
			end
			PH_CMD_ECHO_SEND: begin
				if (is_rx) begin
					phase_d = echo_ok ? PH_BODY_ECHO : PH_IDLE;
				end else if (is_tick && tmo) begin
					phase_d = PH_IDLE;
				end
			end
			PH_CMD_ECHO_RECV: begin
				if (is_rx) begin
					phase_d = echo_ok ? PH_RX_LEN : PH_IDLE;
				end else if (is_tick && tmo) begin
					phase_d = PH_IDLE;
				end
			end
			PH_BODY_ECHO: begin
				if (is_rx) begin
					phase_d = (echo_ok && more) ? PH_BODY_ECHO : PH_IDLE;
				end else if (is_tick && tmo) begin
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		cur_cmd_d  = cur_cmd_q;
		msg_len_d  = msg_len_q;
		byte_cnt_d = byte_cnt_q;
		exp_echo_d = exp_echo_q;
		wait_d     = wait_q;
		res        = '0;
		if (is_tick && phase_q != PH_IDLE && phase_q != PH_AWAIT_REPLY) begin
			wait_d = wait_inc;
			if (tmo) begin
				res.event_res = EvTimeout;
			end
		end
		unique case (phase_q)
			PH_IDLE: begin
				if (is_rx) begin
					res.tx_valid = 1'b1;
					res.tx_byte  = item.value ^ EchoKey;
					wait_d       = '0;
					if (item.value >= CmdHigh) begin
						cur_cmd_d = item.value;
					end else begin
						cur_cmd_d     = item.value & CmdMask;
						res.event_res = EvDataReq;
					end
				end else if (is_send_data || is_send_cmd) begin
					cur_cmd_d    = is_send_data ? cmd_hi : item.value;
					res.tx_valid = 1'b1;
					res.tx_byte  = cur_cmd_d;
					exp_echo_d   = cur_cmd_d ^ EchoKey;
					wait_d       = '0;
					if (is_send_data) begin
						msg_len_d  = clamp_len;
						byte_cnt_d = '0;
					end
				end
			end
			PH_RX_LEN: begin
				if (is_rx) begin
					res.tx_valid = 1'b1;
					res.tx_byte  = item.value ^ EchoKey;
					wait_d       = '0;
					msg_len_d    = item.value;
					byte_cnt_d   = '0;
					if (item.value == 8'd0) begin
						res.event_res = EvEmptyMsg;
					end
				end
			end
			PH_RX_DATA: begin
				if (is_rx) begin
					res.tx_valid  = 1'b1;
					res.tx_byte   = item.value ^ EchoKey;
					wait_d        = '0;
					res.event_res = EvDataByte;
					res.data_out  = item.value;
					res.position  = byte_cnt_q;
					res.last      = fin;
					byte_cnt_d    = 8'(byte_cnt_q + 8'd1);
				end
			end
			PH_AWAIT_REPLY: begin
				if (is_reply) begin
					msg_len_d    = clamp_len;
					byte_cnt_d   = '0;
					res.tx_valid = 1'b1;
					res.tx_byte  = clamp_len;
					exp_echo_d   = clamp_len ^ EchoKey;
					wait_d       = '0;
				end
			end
			PH_CMD_ECHO_SEND, PH_CMD_ECHO_RECV, PH_BODY_ECHO: begin
				if (is_rx) begin
					if (!echo_ok) begin
						res.event_res = EvEchoError;
					end else if (phase_q == PH_CMD_ECHO_RECV) begin
						wait_d = '0;
					end else if (phase_q == PH_CMD_ECHO_SEND) begin
						byte_cnt_d   = '0;
						res.tx_valid = 1'b1;
						res.tx_byte  = msg_len_q;
						exp_echo_d   = msg_len_q ^ EchoKey;
						wait_d       = '0;
					end else if (more) begin
						byte_cnt_d   = 8'(byte_cnt_q + 8'd1);
						res.tx_valid = 1'b1;
						res.tx_byte  = rd_byte;
						exp_echo_d   = rd_byte ^ EchoKey;
						wait_d       = '0;
					end else begin
						res.event_res = EvSendDone;
					end
				end
			end
			default: res = '0;
		endcase
		res.cmd = cur_cmd_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			cur_cmd_q  <= '0;
			msg_len_q  <= '0;
			byte_cnt_q <= '0;
			exp_echo_q <= '0;
			wait_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			cur_cmd_q  <= cur_cmd_d;
			msg_len_q  <= msg_len_d;
			byte_cnt_q <= byte_cnt_d;
			exp_echo_q <= exp_echo_d;
			wait_q     <= wait_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_load && {4'd0, item.index} < StoreB) begin
			store_q[item.index[AW-1:0]] <= item.value;
		end
	end

endmodule

`default_nettype wire

/* sv/eacl_checker.sv */
// Port-level assertions for the echo acknowledge command link, bound to the top level.
`default_nettype none

module eacl_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  res_valid,
	input wire                  res_stall,
	input eacl_pkg::eacl_res_t  res
);
	import eacl_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	a_tx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.tx_valid |-> res.tx_byte == 8'd0)
		else $error("tx byte set without tx valid");

	a_data_echo: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.event_res == EvDataByte |->
		res.tx_valid && res.tx_byte == (res.data_out ^ EchoKey))
		else $error("data byte not echoed");

	a_no_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.event_res != EvDataByte |->
		res.data_out == 8'd0 && res.position == 8'd0 && !res.last)
		else $error("data fields set outside data byte event");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.event_res == EvTimeout || res.event_res == EvEchoError ||
		res.event_res == EvSendDone) |-> !res.tx_valid)
		else $error("transmit on terminating event");

endmodule

bind echo_ack_command_link eacl_checker u_eacl_checker (.*);

`default_nettype wire
